@@ hdl/itcs_pkg.sv @@
// Shared types and constants for the IPv4/TCP capture summarizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package itcs_pkg;

    // Width of the packet count as it leaves the block.
    localparam int PKT_COUNT_W = 32;

    // Byte positions inside the fixed part of the IPv4 header, and of the data offset inside the TCP header.
    localparam logic [15:0] POS_IHL          = 16'd0;
    localparam logic [15:0] POS_TOTLEN_HI    = 16'd2;
    localparam logic [15:0] POS_TOTLEN_LO    = 16'd3;
    localparam logic [15:0] POS_SRC_FIRST    = 16'd12;
    localparam logic [15:0] POS_SRC_LAST     = 16'd15;
    localparam logic [15:0] POS_DST_FIRST    = 16'd16;
    localparam logic [15:0] POS_DST_LAST     = 16'd19;
    localparam logic [15:0] IP_FIXED_BYTES   = 16'd20;
    localparam logic [15:0] POS_FIXED_LAST   = 16'd19;
    localparam logic [15:0] TCP_OFFSET_BYTE  = 16'd12;

    // Header length values below this are treated as this value.
    localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_log;
    } itcs_in_t;

    typedef struct packed {
        logic [31:0]            client_address;
        logic [31:0]            server_address;
        logic [3:0]             first_header_words;
        logic [15:0]            first_total_length;
        logic [3:0]             first_tcp_offset;
        logic [PKT_COUNT_W-1:0] packet_count;
        logic                   any_packet;
    } itcs_out_t;

endpackage

`default_nettype wire

@@ hdl/itcs_parser.sv @@
// Byte-position tracker and first-packet capture logic.
// Depends on itcs_pkg for the item types and header byte positions.
`timescale 1ns / 1ps
`default_nettype none

module itcs_parser
    import itcs_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step,
    input  wire itcs_in_t  in_item,
    output itcs_out_t      summary
);

    logic [15:0]           pos_reg,    pos_next;
    logic [3:0]            hw_reg,     hw_next;
    logic [15:0]           tl_reg,     tl_next;
    logic [31:0]           client_reg, client_next;
    logic [31:0]           server_reg, server_next;
    logic [3:0]            cap_hw_reg, cap_hw_next;
    logic [15:0]           cap_tl_reg, cap_tl_next;
    logic [3:0]            cap_tcp_reg, cap_tcp_next;
    logic [COUNT_BITS-1:0] seen_reg,   seen_next;

    logic [3:0]  eff_words;
    logic [15:0] hdr_end;
    logic [15:0] tcp_pos;
    logic [15:0] pkt_end;
    logic [16:0] pos_inc;
    logic [7:0]  b;
    logic        any;
    logic [PKT_COUNT_W-1:0] count_sat;

    assign b = in_item.byte_value;

    always_comb begin
        hw_next      = hw_reg;
        tl_next      = tl_reg;
        client_next  = client_reg;
        server_next  = server_reg;
        cap_hw_next  = cap_hw_reg;
        cap_tl_next  = cap_tl_reg;
        cap_tcp_next = cap_tcp_reg;
        seen_next    = seen_reg;

        // Header length and total length of the packet in flight.
        if (pos_reg == POS_IHL) begin
            hw_next = b[3:0];
        end else if (pos_reg == POS_TOTLEN_HI) begin
            tl_next = {b, 8'h00};
        end else if (pos_reg == POS_TOTLEN_LO) begin
            tl_next = {tl_reg[15:8], b};
        end

        eff_words = (hw_next < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hw_next;
        hdr_end   = 16'({eff_words, 2'b00}) + IP_FIXED_BYTES;
        tcp_pos   = 16'({eff_words, 2'b00}) + TCP_OFFSET_BYTE;

        // Capture from the first packet only.
        if (seen_reg == '0) begin
            if (pos_reg >= POS_SRC_FIRST && pos_reg <= POS_SRC_LAST) begin
                server_next = {server_reg[23:0], b};
            end else if (pos_reg >= POS_DST_FIRST && pos_reg <= POS_DST_LAST) begin
                client_next = {client_reg[23:0], b};
            end
            if (pos_reg == POS_FIXED_LAST) begin
                cap_hw_next = hw_next;
                cap_tl_next = tl_next;
            end
        end else if (seen_reg == COUNT_BITS'(1) && pos_reg == tcp_pos) begin
            cap_tcp_next = b[7:4];
        end

        if (pos_reg == POS_FIXED_LAST && seen_reg != '1) begin
            seen_next = seen_reg + COUNT_BITS'(1);
        end

        // The packet ends at the larger of the total length and the headers.
        if (pos_reg >= POS_FIXED_LAST && tl_next > hdr_end) begin
            pkt_end = tl_next;
        end else begin
            pkt_end = hdr_end;
        end
        pos_inc = {1'b0, pos_reg} + 17'd1;
        if (pos_inc >= {1'b0, pkt_end}) begin
            pos_next = '0;
        end else begin
            pos_next = pos_inc[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_item.end_of_log)) begin
            pos_reg     <= '0;
            hw_reg      <= '0;
            tl_reg      <= '0;
            client_reg  <= '0;
            server_reg  <= '0;
            cap_hw_reg  <= '0;
            cap_tl_reg  <= '0;
            cap_tcp_reg <= '0;
            seen_reg    <= '0;
        end else if (step) begin
            pos_reg     <= pos_next;
            hw_reg      <= hw_next;
            tl_reg      <= tl_next;
            client_reg  <= client_next;
            server_reg  <= server_next;
            cap_hw_reg  <= cap_hw_next;
            cap_tl_reg  <= cap_tl_next;
            cap_tcp_reg <= cap_tcp_next;
            seen_reg    <= seen_next;
        end
    end

    generate
        if (COUNT_BITS > PKT_COUNT_W) begin : g_wide_count
            assign count_sat = (|seen_reg[COUNT_BITS-1:PKT_COUNT_W]) ? '1
                                                                      : seen_reg[PKT_COUNT_W-1:0];
        end else begin : g_narrow_count
            assign count_sat = PKT_COUNT_W'(seen_reg);
        end
    endgenerate

    assign any = (seen_reg != '0);

    always_comb begin
        summary.client_address     = any ? client_reg  : '0;
        summary.server_address     = any ? server_reg  : '0;
        summary.first_header_words = any ? cap_hw_reg  : '0;
        summary.first_total_length = any ? cap_tl_reg  : '0;
        summary.first_tcp_offset   = any ? cap_tcp_reg : '0;
        summary.packet_count       = count_sat;
        summary.any_packet         = any;
    end

endmodule

`default_nettype wire

@@ hdl/ipv4_tcp_capture_summarizer_core.sv @@
// Top level of the IPv4/TCP capture summarizer: input and result registers
// around the parser. Depends on itcs_pkg and itcs_parser.
//
// Usage: the s_ channel carries a log of back-to-back IPv4+TCP packets, one
// byte per request (end_of_log low). A request with end_of_log high closes
// the log; the block then returns one summary request on the m_ channel with
// the addresses, header length, total length and TCP data offset of the first
// packet and the number of packets seen, and clears itself for the next log.
// Byte requests produce no result.
// Throughput is one request per cycle while no end mark waits behind a pending
// summary: every byte is handled by a position compare and a few field updates
// between the input register and the state; a summary enters the result register
// as its end mark is consumed. When the receiver stalls, the summary waits there;
// bytes keep flowing, and only a second end mark waits in the input register,
// with s_ready low, until the pending summary is taken.
// Reset (aresetn low, synchronous) empties both registers and clears all
// captured fields and the packet count.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_tcp_capture_summarizer_core
    import itcs_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire itcs_in_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output itcs_out_t      m_payload
);

    itcs_in_t  in_reg;
    logic      in_valid_reg;
    itcs_out_t out_reg;
    logic      out_valid_reg;
    itcs_out_t summary;
    logic      consume;

    // The held request moves on unless it is an end mark and the result
    // register still holds a summary that is not being taken.
    assign consume = in_valid_reg &&
                     (!in_reg.end_of_log || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_reg <= s_payload;
        end
    end

    itcs_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .in_item (in_reg),
        .summary (summary)
    );

    // The result register loads a summary as its end mark is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_reg.end_of_log) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_reg.end_of_log) begin
            out_reg <= summary;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // A new summary only appears after an end mark was consumed.
    a_result_from_end_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_reg.end_of_log))
        else $error("summary appeared without an end mark");

    // Input stalls only behind a pending summary.
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_reg.end_of_log && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked summary");

    // An empty log yields an all-zero summary.
    a_empty_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.any_packet) |->
            (m_payload.client_address == '0 && m_payload.server_address == '0 &&
             m_payload.packet_count == '0 && m_payload.first_total_length == '0))
        else $error("summary without packets carries data");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

@@ test/itcs_summary_checker.sv @@
// Scoreboard for the IPv4/TCP capture summarizer: follows the byte stream,
// forecasts each log summary and compares it with the m_ channel.
// Depends on itcs_pkg only.
`timescale 1ns / 1ps

module itcs_summary_checker
    import itcs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire itcs_in_t  s_payload,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire itcs_out_t m_payload,
    output int             summaries_pending,
    output int             mismatch_total
);

    logic [15:0] byte_pos;
    logic [3:0]  hdr_words;
    logic [15:0] total_len;
    logic [31:0] cap_client;
    logic [31:0] cap_server;
    logic [3:0]  cap_hdr_words;
    logic [15:0] cap_total_len;
    logic [3:0]  cap_tcp_offset;
    logic [31:0] pkts_counted;

    itcs_out_t   awaited_summaries[$];
    itcs_out_t   want;
    int          mismatches = 0;

    function automatic void clear_capture();
        byte_pos       = '0;
        hdr_words      = '0;
        total_len      = '0;
        cap_client     = '0;
        cap_server     = '0;
        cap_hdr_words  = '0;
        cap_total_len  = '0;
        cap_tcp_offset = '0;
        pkts_counted   = '0;
    endfunction

    // Advances the parser state by one request; an end mark queues the summary.
    function automatic void absorb_request(input itcs_in_t req);
        itcs_out_t   summary;
        int unsigned pos;
        int unsigned eff_words;
        int unsigned pkt_end;
        logic [7:0]  b;
        pos = 32'(byte_pos);
        b   = req.byte_value;
        if (req.end_of_log) begin
            summary = '0;
            summary.packet_count = pkts_counted;
            if (pkts_counted != 0) begin
                summary.client_address     = cap_client;
                summary.server_address     = cap_server;
                summary.first_header_words = cap_hdr_words;
                summary.first_total_length = cap_total_len;
                summary.first_tcp_offset   = cap_tcp_offset;
                summary.any_packet         = 1'b1;
            end
            awaited_summaries.push_back(summary);
            clear_capture();
        end else begin
            if (pos == POS_IHL) begin
                hdr_words = b[3:0];
            end else if (pos == POS_TOTLEN_HI) begin
                total_len = {b, 8'h00};
            end else if (pos == POS_TOTLEN_LO) begin
                total_len = {total_len[15:8], b};
            end
            eff_words = 32'((hdr_words < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hdr_words);

            if (pkts_counted == 0) begin
                if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
                    cap_server = {cap_server[23:0], b};
                end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
                    cap_client = {cap_client[23:0], b};
                end
                if (pos == POS_FIXED_LAST) begin
                    cap_hdr_words = hdr_words;
                    cap_total_len = total_len;
                end
            end else if (pkts_counted == 1 && pos == 4 * eff_words + TCP_OFFSET_BYTE) begin
                cap_tcp_offset = b[7:4];
            end

            if (pos == POS_FIXED_LAST && pkts_counted != '1) begin
                pkts_counted = pkts_counted + 1;
            end

            pkt_end = 4 * eff_words + IP_FIXED_BYTES;
            if (pos >= POS_FIXED_LAST && total_len > pkt_end) begin
                pkt_end = 32'(total_len);
            end
            byte_pos = (pos + 1 >= pkt_end) ? 16'd0 : 16'(pos + 1);
        end
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, expected, actual);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_capture();
            awaited_summaries.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_summaries.size() == 0) begin
                    $display("%0t ns: summary expected none, got %h", $time, m_payload);
                    mismatches++;
                end else begin
                    want = awaited_summaries.pop_front();
                    compare_field("client_address", want.client_address,
                                  m_payload.client_address);
                    compare_field("server_address", want.server_address,
                                  m_payload.server_address);
                    compare_field("first_header_words", 32'(want.first_header_words),
                                  32'(m_payload.first_header_words));
                    compare_field("first_total_length", 32'(want.first_total_length),
                                  32'(m_payload.first_total_length));
                    compare_field("first_tcp_offset", 32'(want.first_tcp_offset),
                                  32'(m_payload.first_tcp_offset));
                    compare_field("packet_count", want.packet_count,
                                  m_payload.packet_count);
                    compare_field("any_packet", 32'(want.any_packet),
                                  32'(m_payload.any_packet));
                end
            end
            if (s_valid && s_ready) begin
                absorb_request(s_payload);
            end
        end
        summaries_pending <= awaited_summaries.size();
        mismatch_total    <= mismatches;
    end

endmodule

@@ test/ipv4_tcp_capture_summarizer_core_test.sv @@
// Testbench top for the IPv4/TCP capture summarizer: drives packet logs into
// the block and gives the verdict. Depends on itcs_pkg, itcs_summary_checker
// and the block itself.
`timescale 1ns / 1ps

module ipv4_tcp_capture_summarizer_core_test;
    import itcs_pkg::*;

    // Cycles without any accepted request on either channel before giving up.
    // Gaps and stalls are random at most 55 percent, so long quiet runs only
    // happen when the block hangs.
    localparam int QUIET_LIMIT  = 2000;
    // At the end, keep the clock running so that a stray extra summary would
    // still be caught.
    localparam int DRAIN_CYCLES = 12;
    localparam int BYTE_TARGET  = 1600;
    // One round per idling phase at the least.
    localparam int MIN_ROUNDS   = 4;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    itcs_in_t  s_payload = '0;
    logic      m_ready   = 1'b0;
    logic      s_ready;
    logic      m_valid;
    itcs_out_t m_payload;

    int summaries_pending;
    int mismatch_total;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int marks_sent     = 0;
    int rounds_run     = 0;
    int quiet_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ipv4_tcp_capture_summarizer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    itcs_summary_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_payload         (s_payload),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload         (m_payload),
        .summaries_pending (summaries_pending),
        .mismatch_total    (mismatch_total)
    );

    // The receiver drops ready at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: any accepted request on either side counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles at %0t ns.", quiet_cycles, $time);
            $display("[ipv4_tcp_capture_summarizer_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, after a random gap in the idling phases, and holds it
    // until the block takes it. Valid stays high from one request to the next
    // when no gap is drawn, so back-to-back bytes go in at full rate.
    task automatic send_request(input logic mark, input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{byte_value: value, end_of_log: mark};
        do @(posedge aclk); while (!s_ready);
        if (mark) begin
            marks_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    // Sends the first byte_count bytes of a packet. Only the header length
    // nibble and the total length are fixed; the high nibble of byte 0, the
    // addresses, the TCP offset byte and the payload are random.
    task automatic send_packet(input logic [3:0] ihl, input logic [15:0] total_len,
                               input int byte_count);
        logic [7:0] value;
        for (int i = 0; i < byte_count; i++) begin
            value = 8'($urandom_range(0, 255));
            if (i == 0) begin
                value[3:0] = ihl;
            end else if (i == 2) begin
                value = total_len[15:8];
            end else if (i == 3) begin
                value = total_len[7:0];
            end
            send_request(1'b0, value);
        end
    endtask

    // One log closed by an end mark. Most logs are a few well-formed packets;
    // some end in the middle of a packet, some are empty (so end marks come
    // back to back) and some are plain noise.
    task automatic send_log();
        int         n_pkts;
        int         hdr_bytes;
        int         byte_count;
        logic [3:0] ihl;
        logic [15:0] total_len;
        if ($urandom_range(0, 7) == 0) begin
            // Noise still parses as packets of some shape, so it is checked too.
            repeat ($urandom_range(0, 60)) send_request(1'b0, 8'($urandom_range(0, 255)));
        end else begin
            n_pkts = $urandom_range(0, 3);
            for (int p = 0; p < n_pkts; p++) begin
                // A quarter of the packets carry a header length below the
                // minimum, which the block has to treat as five words.
                ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 4))
                                                   : 4'($urandom_range(5, 15));
                hdr_bytes = 4 * int'(ihl < MIN_HEADER_WORDS ? MIN_HEADER_WORDS : ihl)
                            + int'(IP_FIXED_BYTES);
                // The packet ends at the larger of total length and the two
                // headers, so a total length below the headers must be ignored.
                case ($urandom_range(0, 3))
                    0: begin
                        total_len = 16'($urandom_range(0, hdr_bytes));
                    end
                    1: begin
                        total_len = 16'(hdr_bytes);
                    end
                    2: begin
                        total_len = 16'(hdr_bytes + $urandom_range(1, 40));
                    end
                    default: begin
                        total_len = 16'(hdr_bytes + $urandom_range(41, 160));
                    end
                endcase
                if (p == n_pkts - 1 && $urandom_range(0, 2) == 0) begin
                    // Cut the last packet short; the total length may then be
                    // anything, which exercises all of its bits cheaply.
                    total_len  = 16'($urandom_range(0, 65535));
                    byte_count = $urandom_range(1, hdr_bytes);
                end else begin
                    byte_count = (total_len > hdr_bytes) ? int'(total_len) : hdr_bytes;
                end
                send_packet(ihl, total_len, byte_count);
            end
        end
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Holds the sender back until every summary forecast so far has arrived.
    // The checker's count is registered, hence the step before the test.
    task automatic wait_for_summaries();
        s_valid <= 1'b0;
        do @(posedge aclk); while (summaries_pending != 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // An end mark on an empty block: the result is all zero and its byte
        // value must not leak anywhere.
        send_request(1'b1, 8'hff);
        // A log that stops exactly at the 20th byte of its first packet: the
        // packet is counted with every byte at its maximum, while the TCP
        // offset is never reached and must come back as zero.
        repeat (20) send_request(1'b0, 8'hff);
        send_request(1'b1, 8'h00);
        wait_for_summaries();

        // Random logs in rounds that cycle through the idling phases; every
        // round ends with the sender waiting until the block has drained.
        while (bytes_sent < BYTE_TARGET || rounds_run < MIN_ROUNDS) begin
            case (rounds_run % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default: begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            repeat (4) send_log();
            wait_for_summaries();
            rounds_run++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d log bytes and %0d end marks in %0d rounds of mixed idling.",
                 bytes_sent, marks_sent, rounds_run);
        if (mismatch_total == 0) begin
            $display("[ipv4_tcp_capture_summarizer_core] OK");
        end else begin
            $display("[ipv4_tcp_capture_summarizer_core] ERROR");
        end
        $finish;
    end

endmodule
